### rtl/core/gcdw_pkg.sv
// Package for the graph component depth-first walker: sizes, request codes and states.
package gcdw_pkg;

    localparam int MAX_NODES_DEF        = 1024;
    localparam int MAX_EDGE_ENTRIES_DEF = 4096;
    localparam int NODE_W               = 10;

    typedef enum logic
    {
        REQ_ADD_EDGE = 1'b0,
        REQ_FETCH    = 1'b1
    } req_code_t;

    typedef enum logic [4:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_HEAD,
        ST_ADD_HEAD_WAIT,
        ST_ADD_A,
        ST_ADD_B,
        ST_WALK,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_SCAN_TEST,
        ST_NB_RD,
        ST_NB_WAIT,
        ST_NB_LINK,
        ST_NB_LINK_WAIT,
        ST_NB_TGT,
        ST_NB_TGT_WAIT,
        ST_NB_TEST,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_RESULT
    } state_t;

endpackage

### rtl/core/graph_component_dfs_walker.sv
// Top level of the graph component depth-first walker.
//
//  channel   direction  signals
//  request   in         in_valid, in_stall, req_type, node_a, node_b
//  result    out        out_valid, out_stall, node_id, class_start, done_res, overflow
//  config    in         cfg_we, cfg_wdata (node_count)
//
// After reset a clearing pass writes every node row (head, tail, cursor, visited), one row a
// cycle; no request is taken meanwhile. An add-edge request goes through ST_ADD_HEAD,
// ST_ADD_HEAD_WAIT and ST_ADD_A for its first endpoint, then ST_ADD_B, ST_ADD_HEAD_WAIT and
// ST_ADD_A for its second, before ST_RESULT; a dropped edge goes straight to ST_RESULT. The
// cost of a fetch grows with each neighbour-list entry examined, each stack pop and each
// scanned node, so its cost is amortised over the graph. Each memory has a single port. One
// request is handled at a time; the result waits in its output register while out_stall is
// high, and the next request is taken once it has gone.
module graph_component_dfs_walker #(
    parameter int MAX_NODES        = gcdw_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGE_ENTRIES = gcdw_pkg::MAX_EDGE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [gcdw_pkg::NODE_W-1:0] node_a,
    input  logic [gcdw_pkg::NODE_W-1:0] node_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gcdw_pkg::NODE_W-1:0] node_id,
    output logic                        class_start,
    output logic                        done_res,
    output logic                        overflow,
    input  logic                        cfg_we,
    input  logic [gcdw_pkg::NODE_W-1:0] cfg_wdata
);
    import gcdw_pkg::*;

    localparam int NA = $clog2(MAX_NODES);
    localparam int EA = $clog2(MAX_EDGE_ENTRIES);
    // Links carry one more bit so that the value MAX_EDGE_ENTRIES means null.
    localparam int LW = $clog2(MAX_EDGE_ENTRIES + 1);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGE_ENTRIES);
    localparam int TW = (NA > NODE_W) ? NA : NODE_W;

    state_t state_reg, state_next;

    logic [NODE_W-1:0] node_count_reg;
    logic [EA:0]       edges_used_reg, edges_used_next;
    logic [CW-1:0]     stack_depth_reg, stack_depth_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [TW-1:0]     cur_reg, cur_next;
    logic [TW-1:0]     tgt_reg, tgt_next;
    logic              walk_reg, walk_next;
    logic              req_reg, req_next;
    logic [NA-1:0]     a_reg, a_next, b_reg, b_next;
    logic [LW-1:0]     lnk_reg, lnk_next;
    logic [NA:0]       clr_reg, clr_next;

    logic              res_valid_reg, res_valid_next;
    logic [NODE_W-1:0] res_id_reg, res_id_next;
    logic              res_cs_reg, res_cs_next;
    logic              res_done_reg, res_done_next;
    logic              res_ovf_reg, res_ovf_next;

    // Node row memory: head, tail, cursor and visited for one node.
    localparam int RW = 3 * LW + 1;
    logic          nr_we;
    logic [NA-1:0] nr_addr;
    logic [RW-1:0] nr_wdata, nr_rdata;
    logic [LW-1:0] r_head, r_tail, r_cur;
    logic          r_vis;
    logic [LW-1:0] w_head, w_tail, w_cur;
    logic          w_vis;

    logic          et_we, el_we, st_we;
    logic [EA-1:0] et_addr, el_addr;
    logic [TW-1:0] et_wdata, et_rdata;
    logic [LW-1:0] el_wdata, el_rdata;
    logic [NA-1:0] st_addr;
    logic [TW-1:0] st_wdata, st_rdata;

    assign {r_head, r_tail, r_cur, r_vis} = nr_rdata;
    assign nr_wdata = {w_head, w_tail, w_cur, w_vis};

    gcdw_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_nodes
    (
        .clk(clk), .we(nr_we), .addr(nr_addr), .wdata(nr_wdata), .rdata(nr_rdata)
    );
    gcdw_ram #(.WIDTH(TW), .DEPTH(MAX_EDGE_ENTRIES)) u_target
    (
        .clk(clk), .we(et_we), .addr(et_addr), .wdata(et_wdata), .rdata(et_rdata)
    );
    gcdw_ram #(.WIDTH(LW), .DEPTH(MAX_EDGE_ENTRIES)) u_link
    (
        .clk(clk), .we(el_we), .addr(el_addr), .wdata(el_wdata), .rdata(el_rdata)
    );
    gcdw_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_stack
    (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
    );

    logic accept;
    logic scan_ok;
    assign in_stall  = (state_reg != ST_IDLE) || res_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign node_id   = res_id_reg;
    assign class_start = res_cs_reg;
    assign done_res  = res_done_reg;
    assign overflow  = res_ovf_reg;

    // The scan stops at node_count and at the last node that exists.
    assign scan_ok = (32'(pos_reg) <= 32'(node_count_reg)) && (32'(pos_reg) < 32'(MAX_NODES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            node_count_reg  <= NODE_W'(1023);
            edges_used_reg  <= '0;
            stack_depth_reg <= '0;
            scan_reg        <= '0;
            cur_reg         <= '0;
            walk_reg        <= 1'b0;
            clr_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            edges_used_reg  <= edges_used_next;
            stack_depth_reg <= stack_depth_next;
            scan_reg        <= scan_next;
            cur_reg         <= cur_next;
            walk_reg        <= walk_next;
            clr_reg         <= clr_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        tgt_reg      <= tgt_next;
        req_reg      <= req_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        lnk_reg      <= lnk_next;
        res_id_reg   <= res_id_next;
        res_cs_reg   <= res_cs_next;
        res_done_reg <= res_done_next;
        res_ovf_reg  <= res_ovf_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        edges_used_next  = edges_used_reg;
        stack_depth_next = stack_depth_reg;
        scan_next        = scan_reg;
        pos_next         = pos_reg;
        cur_next         = cur_reg;
        tgt_next         = tgt_reg;
        walk_next        = walk_reg;
        req_next         = req_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        lnk_next         = lnk_reg;
        clr_next         = clr_reg;
        res_valid_next   = res_valid_reg && out_stall;
        res_id_next      = res_id_reg;
        res_cs_next      = res_cs_reg;
        res_done_next    = res_done_reg;
        res_ovf_next     = res_ovf_reg;
        nr_we    = 1'b0;
        nr_addr  = NA'(cur_reg);
        w_head   = r_head;
        w_tail   = r_tail;
        w_cur    = r_cur;
        w_vis    = r_vis;
        et_we    = 1'b0;
        et_addr  = edges_used_reg[EA-1:0];
        et_wdata = '0;
        el_we    = 1'b0;
        el_addr  = edges_used_reg[EA-1:0];
        el_wdata = NULL_LINK;
        st_we    = 1'b0;
        st_addr  = NA'(stack_depth_reg);
        st_wdata = cur_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                nr_we   = 1'b1;
                nr_addr = clr_reg[NA-1:0];
                w_head  = NULL_LINK;
                w_tail  = NULL_LINK;
                w_cur   = NULL_LINK;
                w_vis   = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (NA+1)'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next = NA'(node_a);
                    b_next = NA'(node_b);
                    res_id_next   = '0;
                    res_cs_next   = 1'b0;
                    res_done_next = 1'b0;
                    res_ovf_next  = 1'b0;
                    if (req_type == REQ_FETCH)
                    begin
                        state_next = ST_WALK;
                    end
                    else if ((32'(node_a) >= 32'(MAX_NODES)) || (32'(node_b) >= 32'(MAX_NODES)))
                    begin
                        state_next = ST_RESULT;
                    end
                    else if (edges_used_reg + 2 > (EA+1)'(MAX_EDGE_ENTRIES))
                    begin
                        res_ovf_next = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        req_next   = 1'b0;
                        state_next = ST_ADD_HEAD;
                    end
                end
            end
            // req_reg selects the endpoint: 0 appends b to a, 1 appends a to b.
            ST_ADD_HEAD:
            begin
                nr_addr    = req_reg ? b_reg : a_reg;
                state_next = ST_ADD_HEAD_WAIT;
            end
            ST_ADD_HEAD_WAIT:
            begin
                nr_addr  = req_reg ? b_reg : a_reg;
                et_we    = 1'b1;
                et_wdata = TW'(req_reg ? a_reg : b_reg);
                el_we    = 1'b1;
                el_wdata = NULL_LINK;
                lnk_next = r_tail;
                nr_we    = 1'b1;
                w_tail   = LW'(edges_used_reg);
                if (r_head == NULL_LINK)
                begin
                    w_head = LW'(edges_used_reg);
                end
                state_next = ST_ADD_A;
            end
            ST_ADD_A:
            begin
                if (lnk_reg != NULL_LINK)
                begin
                    el_we    = 1'b1;
                    el_addr  = lnk_reg[EA-1:0];
                    el_wdata = LW'(edges_used_reg);
                end
                edges_used_next = edges_used_reg + 1'b1;
                if (req_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    req_next   = 1'b1;
                    state_next = ST_ADD_B;
                end
            end
            ST_ADD_B:
            begin
                nr_addr    = b_reg;
                state_next = ST_ADD_HEAD_WAIT;
            end
            ST_WALK:
            begin
                if (!walk_reg)
                begin
                    pos_next   = scan_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_NB_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (!scan_ok)
                begin
                    if (pos_reg - 1'b1 > scan_reg)
                    begin
                        scan_next = pos_reg - 1'b1;
                    end
                    res_done_next = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    nr_addr    = NA'(pos_reg);
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                nr_addr = NA'(pos_reg);
                if (r_vis)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    nr_we       = 1'b1;
                    w_vis       = 1'b1;
                    scan_next   = pos_reg;
                    cur_next    = TW'(pos_reg);
                    walk_next   = 1'b1;
                    res_id_next = NODE_W'(pos_reg);
                    res_cs_next = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_NB_RD:
            begin
                state_next = ST_NB_WAIT;
            end
            ST_NB_WAIT:
            begin
                lnk_next   = r_cur;
                state_next = (r_cur == NULL_LINK) ? ST_NB_LINK_WAIT : ST_NB_LINK;
            end
            ST_NB_LINK:
            begin
                el_addr    = lnk_reg[EA-1:0];
                state_next = ST_NB_LINK_WAIT;
            end
            ST_NB_LINK_WAIT:
            begin
                // A null cursor continues from the head kept in the row output.
                lnk_next = (lnk_reg == NULL_LINK) ? r_head : el_rdata;
                state_next = ST_NB_TGT;
            end
            ST_NB_TGT:
            begin
                if (lnk_reg >= NULL_LINK)
                begin
                    if (stack_depth_reg == '0)
                    begin
                        walk_next  = 1'b0;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        stack_depth_next = stack_depth_reg - 1'b1;
                        state_next       = ST_POP_RD;
                    end
                end
                else
                begin
                    nr_we      = 1'b1;
                    w_cur      = lnk_reg;
                    et_addr    = lnk_reg[EA-1:0];
                    state_next = ST_NB_TGT_WAIT;
                end
            end
            ST_NB_TGT_WAIT:
            begin
                tgt_next   = et_rdata;
                nr_addr    = NA'(et_rdata);
                state_next = ST_NB_TEST;
            end
            ST_NB_TEST:
            begin
                nr_addr = NA'(tgt_reg);
                if ((32'(tgt_reg) < 32'(MAX_NODES)) && !r_vis)
                begin
                    nr_we = 1'b1;
                    w_vis = 1'b1;
                    if (stack_depth_reg < CW'(MAX_NODES))
                    begin
                        st_we            = 1'b1;
                        stack_depth_next = stack_depth_reg + 1'b1;
                    end
                    cur_next    = tgt_reg;
                    res_id_next = NODE_W'(tgt_reg);
                    state_next  = ST_RESULT;
                end
                else
                begin
                    state_next = ST_NB_RD;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                cur_next   = st_rdata;
                state_next = ST_NB_RD;
            end
            ST_RESULT:
            begin
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Results are never produced while the row memory is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid)
        else $error("result during clearing pass");

    // The fill count never passes the edge store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        edges_used_reg <= (EA+1)'(MAX_EDGE_ENTRIES))
        else $error("edge store overfilled");

    // A result carries at most one of its flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({class_start, done_res, overflow}) <= 1)
        else $error("conflicting result flags");

    // A request accepted leaves the idle state at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted but not started");
endmodule

### rtl/core/gcdw_ram.sv
// Generic single-port RAM with a registered read.
module gcdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
